[src/ppfs_pkg.sv]
// shared types and constants for the per-pixel frame stacker
package ppfs_pkg;
    localparam int SAMPLE_W = 32;
    localparam int COUNT_W = 7;
    localparam int CLIP_W = 15;
    localparam logic [CLIP_W-1:0] CLIP_MAX = 15'd32112;
    localparam logic [CLIP_W-1:0] CLIP_RESET = 15'd6553;
    localparam logic MODE_MEDIAN = 1'b0;
    localparam logic MODE_WINSOR = 1'b1;
    localparam logic [0:0] REG_COMBINE_MODE = 1'd0;
    localparam logic [0:0] REG_CLIP_FRACTION = 1'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic last;
    } t_req;
endpackage

[src/ppfs_front.sv]
// input front end: takes requests into a short queue
module ppfs_front #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  ppfs_pkg::t_req i_req,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output ppfs_pkg::t_req o_req
);
    import ppfs_pkg::*;
    localparam int AW = $clog2(DEPTH);
    t_req r_q [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;

    assign o_full = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_req = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

[src/ppfs_back.sv]
// back end: sorted insertion into a memory and final combine
module ppfs_back #(
    parameter int MAX_FRAMES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  ppfs_pkg::t_req i_req,
    input  logic i_mode,
    input  logic [ppfs_pkg::CLIP_W-1:0] i_clip,
    output logic o_pop,
    output logic o_done,
    output logic signed [ppfs_pkg::SAMPLE_W-1:0] o_value,
    output logic [ppfs_pkg::COUNT_W-1:0] o_frames,
    output logic o_ovf
);
    import ppfs_pkg::*;
    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int SW = SAMPLE_W + CW + 1;
    localparam int QW = SW;

    localparam logic [3:0] S_IDLE = 4'd0, S_SHIFT_RD = 4'd1, S_SHIFT_CMP = 4'd2,
        S_PLACE = 4'd3, S_CHK = 4'd4, S_G = 4'd5, S_RD = 4'd6, S_ACC = 4'd7,
        S_DIV = 4'd8, S_OUT = 4'd9, S_MED2 = 4'd10;

    logic [3:0] r_st;
    logic signed [SAMPLE_W-1:0] r_mem [MAX_FRAMES];
    logic signed [SAMPLE_W-1:0] r_rd;
    logic signed [SAMPLE_W-1:0] r_s;
    logic r_last;
    logic [CW-1:0] r_cnt, r_k, r_n, r_g, r_j;
    logic r_drop;
    logic signed [SW-1:0] r_sum;
    logic signed [SAMPLE_W-1:0] r_lo, r_hi;
    logic [QW-1:0] r_rem, r_q;
    logic [$clog2(QW+1)-1:0] r_bit;
    logic r_neg;
    logic [AW-1:0] r_raddr;
    logic [AW-1:0] r_waddr;
    logic signed [SAMPLE_W-1:0] r_wdata;
    logic r_we;
    logic [1:0] r_phase;

    logic [CLIP_W-1:0] w_clip;
    logic [CLIP_W+CW-1:0] w_prod;
    logic [QW:0] w_trial;
    logic signed [SAMPLE_W:0] w_pair;

    assign w_clip = (i_clip > CLIP_MAX) ? CLIP_MAX : i_clip;
    assign w_prod = w_clip * (CLIP_W+CW)'(r_n);
    assign w_trial = {r_rem, r_sum[QW-1 - 0]} - {1'b0, (QW)'(r_n)};
    assign w_pair = (SAMPLE_W+1)'(r_lo) + (SAMPLE_W+1)'(r_rd);

    assign o_pop = (r_st == S_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_waddr] <= r_wdata;
        r_rd <= r_mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_drop <= 1'b0;
            r_we <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_we <= 1'b0;
            o_done <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_s <= i_req.sample;
                        r_last <= i_req.last;
                        if (r_cnt >= CW'(MAX_FRAMES)) begin
                            r_drop <= 1'b1;
                            r_st <= S_CHK;
                        end else begin
                            r_k <= r_cnt;
                            r_st <= (r_cnt == '0) ? S_PLACE : S_SHIFT_RD;
                            r_raddr <= AW'(r_cnt - 1'b1);
                        end
                    end
                end
                S_SHIFT_RD: r_st <= S_SHIFT_CMP; // read latency
                S_SHIFT_CMP: begin
                    if (r_rd > r_s) begin
                        // move the larger entry up one slot
                        r_we <= 1'b1;
                        r_waddr <= AW'(r_k);
                        r_wdata <= r_rd;
                        r_k <= r_k - 1'b1;
                        if (r_k == CW'(1)) begin
                            r_st <= S_PLACE;
                        end else begin
                            r_raddr <= AW'(r_k - CW'(2));
                            r_st <= S_SHIFT_RD;
                        end
                    end else begin
                        r_st <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_we <= 1'b1;
                    r_waddr <= AW'(r_k);
                    r_wdata <= r_s;
                    r_cnt <= r_cnt + 1'b1;
                    r_st <= S_CHK;
                end
                S_CHK: begin
                    if (r_last) begin
                        r_n <= r_cnt;
                        r_st <= S_G;
                    end else begin
                        r_st <= S_IDLE;
                    end
                end
                S_G: begin
                    r_sum <= '0;
                    if (i_mode == MODE_MEDIAN) begin
                        r_phase <= r_n[0] ? 2'd1 : 2'd0;
                        r_raddr <= r_n[0] ? AW'(r_n >> 1) : AW'((r_n >> 1) - 1'b1);
                        r_st <= S_MED2;
                    end else begin
                        r_phase <= 2'd0;
                        r_g <= CW'(w_prod >> 16);
                        r_raddr <= AW'(CW'(w_prod >> 16));
                        r_st <= S_RD;
                    end
                end
                S_MED2: begin
                    // phase 0/1 wait, 2 capture low, 3 hand over to the output state
                    case (r_phase)
                        2'd0: r_phase <= 2'd2;
                        2'd1: r_phase <= 2'd3;
                        2'd2: begin
                            r_lo <= r_rd;
                            r_raddr <= AW'(r_n >> 1);
                            r_phase <= 2'd1;
                            r_n[0] <= 1'b0;
                        end
                        default: begin
                            r_st <= S_OUT;
                        end
                    endcase
                end
                S_RD: begin
                    // fetch lower clamp, then upper clamp, then stream
                    case (r_phase)
                        2'd0: begin
                            r_phase <= 2'd1;
                            r_raddr <= AW'(r_n - 1'b1 - r_g);
                        end
                        2'd1: begin
                            r_lo <= r_rd;
                            r_phase <= 2'd2;
                            r_j <= '0;
                            r_raddr <= '0;
                        end
                        2'd2: begin
                            r_hi <= r_rd;
                            r_phase <= 2'd3;
                            r_raddr <= AW'(CW'(1));
                            r_st <= S_ACC;
                        end
                        default: begin
                            r_st <= S_ACC;
                        end
                    endcase
                end
                S_ACC: begin
                    if (r_j < r_g) r_sum <= r_sum + SW'(r_lo);
                    else if (r_j >= r_n - r_g) r_sum <= r_sum + SW'(r_hi);
                    else r_sum <= r_sum + SW'(r_rd);
                    r_raddr <= AW'(r_j + CW'(2));
                    r_j <= r_j + 1'b1;
                    if (r_j == r_n - 1'b1) begin
                        r_st <= S_DIV;
                        r_bit <= '0;
                        r_rem <= '0;
                        r_q <= '0;
                    end
                end
                S_DIV: begin
                    if (r_bit == '0 && r_q == '0 && r_rem == '0 && !r_neg && r_sum[SW-1]) begin
                        r_neg <= 1'b1;
                        r_sum <= -r_sum;
                    end else if (r_bit == ($clog2(QW+1))'(QW)) begin
                        r_st <= S_OUT;
                    end else begin
                        // restoring division, msb first
                        if (!w_trial[QW]) begin
                            r_rem <= w_trial[QW-1:0];
                            r_q <= {r_q[QW-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[QW-2:0], r_sum[QW-1]};
                            r_q <= {r_q[QW-2:0], 1'b0};
                        end
                        r_sum <= r_sum <<< 1;
                        r_bit <= r_bit + 1'b1;
                    end
                end
                S_OUT: begin
                    o_done <= 1'b1;
                    o_frames <= COUNT_W'(r_cnt);
                    o_ovf <= r_drop;
                    if (i_mode == MODE_MEDIAN) begin
                        // odd count keeps the middle entry as read
                        if (r_n[0])
                            o_value <= r_rd;
                        else
                            o_value <= w_pair[SAMPLE_W:1];
                    end else begin
                        o_value <= r_neg ? -SAMPLE_W'(r_q) : SAMPLE_W'(r_q);
                    end
                    r_cnt <= '0;
                    r_drop <= 1'b0;
                    r_neg <= 1'b0;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
            if (r_st == S_IDLE) r_neg <= 1'b0;
        end
    end
endmodule

[src/per_pixel_frame_stacker_core.sv]
// top level of the per-pixel frame stacker
// channel  | handshake            | payload
// request  | i_start / o_busy     | i_sample, i_last_frame
// result   | o_done strobe        | o_stacked_value, o_frames_used, o_overflow
// config   | i_cfg_we             | i_cfg_index, i_cfg_data
// each sample is inserted in the back end by shifting larger entries up, then placing it;
// closing a set runs the sum and the bit-serial divide in mean mode,
// and reads the middle entry or the middle pair in median mode.
// a four-entry queue lets requests arrive while the back end works; busy rises when full.
// reset is synchronous and clears counts, queue and configuration registers; results cannot be stalled.
module per_pixel_frame_stacker_core #(
    parameter int MAX_FRAMES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    input  logic signed [ppfs_pkg::SAMPLE_W-1:0] i_sample,
    input  logic i_last_frame,
    output logic o_done,
    output logic signed [ppfs_pkg::SAMPLE_W-1:0] o_stacked_value,
    output logic [ppfs_pkg::COUNT_W-1:0] o_frames_used,
    output logic o_overflow,
    input  logic i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [ppfs_pkg::CLIP_W-1:0] i_cfg_data
);
    import ppfs_pkg::*;
    logic r_mode;
    logic [CLIP_W-1:0] r_clip;
    t_req w_in, w_head;
    logic w_full, w_empty, w_pop;

    assign o_busy = w_full;
    assign w_in.sample = i_sample;
    assign w_in.last = i_last_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_WINSOR;
            r_clip <= CLIP_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_COMBINE_MODE) r_mode <= i_cfg_data[0];
            else r_clip <= i_cfg_data;
        end
    end

    ppfs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_start && !w_full), .i_req(w_in), .i_pop(w_pop),
        .o_full(w_full), .o_empty(w_empty), .o_req(w_head)
    );

    ppfs_back #(.MAX_FRAMES(MAX_FRAMES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(!w_empty), .i_req(w_head), .i_mode(r_mode), .i_clip(r_clip),
        .o_pop(w_pop), .o_done(o_done),
        .o_value(o_stacked_value), .o_frames(o_frames_used), .o_ovf(o_overflow)
    );
endmodule

[src/ppfs_checker.sv]
// port-level checks for the frame stacker core, bound to the top level
module ppfs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_done,
    input logic [6:0] o_frames_used,
    input logic o_busy
);
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held two cycles");
    a_frames_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_frames_used != 7'd0) else $error("empty set reported");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && !o_busy) else $error("activity after reset");
endmodule

bind per_pixel_frame_stacker_core ppfs_checker u_ppfs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_done(o_done),
    .o_frames_used(o_frames_used), .o_busy(o_busy)
);

[tb/tb_per_pixel_frame_stacker_core.sv]
// self-checking testbench for the per-pixel frame stacker core
typedef struct {
    logic signed [ppfs_pkg::SAMPLE_W-1:0] value;
    logic [ppfs_pkg::COUNT_W-1:0] used;
    logic ovf;
} t_pixel_result;

class stack_scoreboard;
    localparam int DEPTH = 64;
    logic signed [ppfs_pkg::SAMPLE_W-1:0] store[DEPTH];
    int unsigned count;
    bit dropped;
    logic mode;
    logic [ppfs_pkg::CLIP_W-1:0] clip;
    t_pixel_result pixel_q[$];
    int errors;

    function void clear_all();
        mode = ppfs_pkg::MODE_WINSOR;
        clip = ppfs_pkg::CLIP_RESET;
        count = 0;
        dropped = 0;
        errors = 0;
        pixel_q.delete();
    endfunction

    function logic signed [ppfs_pkg::SAMPLE_W-1:0] combine_pixel(int unsigned n);
        longint acc;
        int unsigned g;
        int unsigned c;
        logic signed [ppfs_pkg::SAMPLE_W-1:0] v;
        acc = 0;
        if (mode == ppfs_pkg::MODE_MEDIAN) begin
            if (n % 2) return store[n/2];
            acc = longint'(store[n/2-1]) + longint'(store[n/2]);
            // arithmetic shift gives the floor for negative sums
            acc = acc >>> 1;
            return acc[31:0];
        end
        c = (clip > ppfs_pkg::CLIP_MAX) ? ppfs_pkg::CLIP_MAX : clip;
        g = (c * n) >> 16;
        for (int unsigned j = 0; j < n; j++) begin
            v = store[j];
            if (j < g) v = store[g];
            else if (j >= n - g) v = store[n-1-g];
            acc += longint'(v);
        end
        acc = acc / longint'(n);
        return acc[31:0];
    endfunction

    function void note_request(logic signed [ppfs_pkg::SAMPLE_W-1:0] s, logic last);
        int unsigned k;
        t_pixel_result r;
        if (count >= DEPTH) begin
            dropped = 1;
        end else begin
            k = count;
            while (k > 0 && store[k-1] > s) begin
                store[k] = store[k-1];
                k--;
            end
            store[k] = s;
            count++;
        end
        if (last) begin
            r.value = combine_pixel(count);
            r.used = count[6:0];
            r.ovf = dropped;
            pixel_q.push_back(r);
            count = 0;
            dropped = 0;
        end
    endfunction

    function void check_result(logic signed [ppfs_pkg::SAMPLE_W-1:0] v,
                               logic [ppfs_pkg::COUNT_W-1:0] u, logic o);
        t_pixel_result r;
        if (pixel_q.size() == 0) begin
            $display("%0t: unexpected result value %0d used %0d ovf %0d", $time, v, u, o);
            errors++;
            return;
        end
        r = pixel_q.pop_front();
        if (v !== r.value) begin
            $display("%0t: stacked_value exp %0d got %0d", $time, r.value, v);
            errors++;
        end
        if (u !== r.used) begin
            $display("%0t: frames_used exp %0d got %0d", $time, r.used, u);
            errors++;
        end
        if (o !== r.ovf) begin
            $display("%0t: overflow exp %0d got %0d", $time, r.ovf, o);
            errors++;
        end
    endfunction
endclass

module tb_per_pixel_frame_stacker_core;
    import ppfs_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    logic o_busy;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic i_last_frame;
    logic o_done;
    logic signed [SAMPLE_W-1:0] o_stacked_value;
    logic [COUNT_W-1:0] o_frames_used;
    logic o_overflow;
    logic i_cfg_we;
    logic [0:0] i_cfg_index;
    logic [CLIP_W-1:0] i_cfg_data;

    stack_scoreboard pixel_sb;
    int unsigned items_sent;

    per_pixel_frame_stacker_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_sample(i_sample), .i_last_frame(i_last_frame), .o_done(o_done),
        .o_stacked_value(o_stacked_value), .o_frames_used(o_frames_used),
        .o_overflow(o_overflow), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            pixel_sb.check_result(o_stacked_value, o_frames_used, o_overflow);
    end

    // called at a clock edge; returns at the edge that accepted the request
    task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic last);
        int unsigned gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1;
        i_sample <= s;
        i_last_frame <= last;
        do @(posedge i_clk); while (o_busy);
        pixel_sb.note_request(s, last);
        items_sent++;
    endtask

    // called at a clock edge; start drops before the next edge
    task automatic write_reg(logic [0:0] idx, logic [CLIP_W-1:0] val);
        i_start <= 0;
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == REG_COMBINE_MODE) pixel_sb.mode = val[0];
        else pixel_sb.clip = val;
    endtask

    task automatic drain_results();
        i_start <= 0;
        @(posedge i_clk);
        while (pixel_sb.pixel_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff - $urandom_range(0, 3);
            1: return 32'sh80000000 + $urandom_range(0, 3);
            2, 3: return $signed($urandom_range(0, 40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_pixel(int unsigned n);
        for (int unsigned k = 1; k <= n; k++)
            send_sample(pick_sample(), k == n);
    endtask

    initial begin
        int unsigned n;
        int unsigned r;
        logic [CLIP_W-1:0] cv;
        pixel_sb = new();
        pixel_sb.clear_all();
        items_sent = 0;
        i_rst_n = 0;
        i_start = 0;
        i_sample = 0;
        i_last_frame = 0;
        i_cfg_we = 0;
        i_cfg_index = REG_COMBINE_MODE;
        i_cfg_data = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: single samples and an extreme pair under reset settings
        send_sample(32'sh7fffffff, 1'b1);
        send_sample(32'sh80000000, 1'b1);
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh80000000, 1'b1);
        drain_results();
        write_reg(REG_COMBINE_MODE, CLIP_W'(MODE_MEDIAN));
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh7fffffff, 1'b1);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh80000000, 1'b1);
        // negative odd sum rounds down
        send_sample(-3, 1'b0);
        send_sample(0, 1'b1);
        send_sample(5, 1'b0);
        send_sample(-7, 1'b0);
        send_sample(2, 1'b1);
        drain_results();
        write_reg(REG_COMBINE_MODE, CLIP_W'(MODE_WINSOR));
        // clip above the limit saturates
        write_reg(REG_CLIP_FRACTION, 15'h7fff);
        for (int k = 0; k < 5; k++) send_sample(k * 1000 - 77, k == 4);
        drain_results();
        write_reg(REG_CLIP_FRACTION, 15'd0);
        send_sample(-1, 1'b0);
        send_sample(-2, 1'b0);
        send_sample(0, 1'b1);
        drain_results();

        for (int phase = 0; phase < 10; phase++) begin
            write_reg(REG_COMBINE_MODE, CLIP_W'(phase % 2));
            case (phase % 5)
                0: cv = '0;
                1: cv = CLIP_MAX;
                2: cv = 15'h7fff;
                3: cv = CLIP_RESET;
                default: cv = CLIP_W'($urandom_range(0, 32767));
            endcase
            write_reg(REG_CLIP_FRACTION, cv);
            while (items_sent < 25 + (phase + 1) * 113) begin
                r = $urandom_range(0, 99);
                if (r < 88) n = $urandom_range(1, 12);
                else if (r < 97) n = $urandom_range(13, 63);
                else n = $urandom_range(64, 70);
                send_pixel(n);
            end
            drain_results();
        end

        if (pixel_sb.errors == 0 && pixel_sb.pixel_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[filelist.f]
src/ppfs_pkg.sv
src/ppfs_front.sv
src/ppfs_back.sv
src/per_pixel_frame_stacker_core.sv
src/ppfs_checker.sv
tb/tb_per_pixel_frame_stacker_core.sv
